@@ rtl/core/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache: payload structs,
// entry count, index widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Number of entry slots
  localparam int ENTRIES = 16;
  // Slot index width
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Counter width able to hold ENTRIES itself
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  // Capacity register width
  localparam int CAP_W   = 5;
  // Common width for capacity/count compares
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W  = 32;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Result of a get that misses
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture a new item, restart search
    logic srch;     // step the key search one entry
    logic decide;   // update ranks, write stores, set result
    logic capture;  // take the value read on a get hit
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic srch_last;  // last entry compared this cycle
    logic get_hit;    // current item is a get that found its key
  } dp_stat_t;

endpackage

@@ rtl/core/lkvc_ram.sv @@
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for one operation: accept, key search, decide, optional value
// read, then hold the result until it is taken.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lkvc_pkg::dp_stat_t    stat,
  output lkvc_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SRCH   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_READ   = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (stat.srch_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = stat.get_hit ? ST_READ : ST_OUT;
      end
      ST_READ: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive handshakes and datapath commands
  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_OUT);
  assign cmd.load    = (state_r == ST_IDLE) && in_valid;
  assign cmd.srch    = (state_r == ST_SRCH);
  assign cmd.decide  = (state_r == ST_DECIDE);
  assign cmd.capture = (state_r == ST_READ);

endmodule

@@ rtl/core/lkvc_dp.sv @@
// ----------------------------------------------------------------------------
// lkvc_dp
// Datapath: key and value RAMs, per-entry valid bits and recency ranks,
// entry count, capacity register, search counter and result register.
// ----------------------------------------------------------------------------
module lkvc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lkvc_pkg::in_t                   in_data,
  input  logic                            cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]      cfg_wdata,
  input  lkvc_pkg::ctrl_cmd_t             cmd,
  output lkvc_pkg::dp_stat_t              stat,
  output lkvc_pkg::out_t                  out_data
);

  localparam int IDX_W = lkvc_pkg::IDX_W;
  localparam int CNT_W = lkvc_pkg::CNT_W;
  localparam int CMP_W = lkvc_pkg::CMP_W;
  localparam int N     = lkvc_pkg::ENTRIES;

  // Item and search state
  lkvc_pkg::in_t             item_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      found_r;
  logic [IDX_W-1:0]          found_idx_r;

  // Entry bookkeeping
  logic [N-1:0]              valid_r;
  logic [IDX_W-1:0]          rank_r [N];
  logic [CNT_W-1:0]          count_r;
  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  lkvc_pkg::out_t            out_r;

  // RAM ports
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [lkvc_pkg::DATA_W-1:0] key_rd;
  logic [lkvc_pkg::DATA_W-1:0] val_rd;

  // Search compare
  logic [IDX_W-1:0]          cmp_idx;
  logic                      cmp_hit;

  // Decide terms
  logic [CMP_W-1:0]          cap_ext;
  logic [CMP_W-1:0]          eff_cap;
  logic                      have_free;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          worst_idx;
  logic [IDX_W-1:0]          last_rank;
  logic [IDX_W-1:0]          tgt;
  logic [IDX_W-1:0]          tgt_rank;
  logic                      is_put;
  logic                      do_touch;
  logic                      do_insert;

  lkvc_ram #(.WIDTH(lkvc_pkg::DATA_W), .DEPTH(N)) u_key_ram (
    .clk   (clk),
    .we    (ram_we && !found_r),
    .waddr (ram_waddr),
    .wdata (item_r.key),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (key_rd)
  );

  lkvc_ram #(.WIDTH(lkvc_pkg::DATA_W), .DEPTH(N)) u_val_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item_r.value),
    .raddr (found_idx_r),
    .rdata (val_rd)
  );

  // Compare the entry whose key arrives this cycle
  assign cmp_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign cmp_hit = cmd.srch && (cnt_r != '0) && valid_r[cmp_idx] &&
                   (key_rd == item_r.key) && !found_r;

  // Clamp capacity to 1 .. ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(N)) begin
      eff_cap = CMP_W'(N);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Lowest free slot and least recent valid slot
  assign last_rank = IDX_W'(count_r - CNT_W'(1));
  always_comb begin
    free_idx  = '0;
    worst_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      if (valid_r[i] && (rank_r[i] == last_rank)) begin
        worst_idx = IDX_W'(i);
      end
    end
  end

  // Pick target slot and update kind
  assign is_put    = (item_r.op == lkvc_pkg::OP_PUT);
  assign have_free = (CMP_W'(count_r) < eff_cap);
  assign tgt       = found_r ? found_idx_r : (have_free ? free_idx : worst_idx);
  assign tgt_rank  = rank_r[tgt];
  assign do_touch  = cmd.decide && (found_r || (is_put && !have_free));
  assign do_insert = cmd.decide && is_put && !found_r && have_free;
  assign ram_we    = cmd.decide && is_put;
  assign ram_waddr = tgt;

  // Item capture, search counter and match tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
    end else if (cmd.load) begin
      cnt_r       <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
    end else if (cmd.srch) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cmp_hit) begin
        found_r     <= 1'b1;
        found_idx_r <= cmp_idx;
      end
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Valid bits and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (do_insert) begin
      valid_r[tgt] <= 1'b1;
      count_r      <= count_r + CNT_W'(1);
    end
  end

  // Recency ranks, one lane per entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < N; i++) begin
        if (do_touch || do_insert) begin
          if (IDX_W'(i) == tgt) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (do_insert || (rank_r[i] < tgt_rank))) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_r.hit        <= found_r;
      out_r.read_value <= is_put ? '0 : lkvc_pkg::MISS_VALUE;
    end else if (cmd.capture) begin
      out_r.read_value <= val_rd;
    end
  end

  assign stat.srch_last = cmd.srch && (cnt_r == CNT_W'(N));
  assign stat.get_hit   = !is_put && found_r;
  assign out_data       = out_r;

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// Usage:
//   in_valid/in_ready carries in_data (op, key, value): get looks a key up,
//   put inserts or updates it. Each item gives one result on
//   out_valid/out_ready: hit, and read_value (stored value on a get hit,
//   all ones on a get miss, zero for a put). cfg_we writes cfg_wdata into
//   the capacity register (0 acts as 1, values above the entry count act as
//   the entry count); write only while idle.
// Timing:
//   One operation at a time: a key search at one entry per cycle, with the
//   key RAM read registered, then a decide step and, for a get hit, a value
//   read step before out_valid rises; the next item is taken the cycle after
//   the result transfer.
// Reset: rst_n clears all valid bits, ranks and the entry count and sets the
//   capacity to 16. Key and value RAMs are not cleared.
// Stall: the result is held until out_ready; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lkvc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lkvc_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata
);

  lkvc_pkg::ctrl_cmd_t cmd;
  lkvc_pkg::dp_stat_t  stat;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lkvc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
